// ===== rtl/stwm_pkg.sv =====
// ----------------------------------------------------------------------------
// stwm_pkg
// Shared types and constants for the sorted two-way merge block.
// ----------------------------------------------------------------------------
package stwm_pkg;

    localparam int COMMAND_W      = 2;
    localparam int VALUE_W        = 64;
    localparam int LIST_DEPTH_DEF = 32;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_MERGE       = 2'd2
    } t_command;

    // controller to datapath
    typedef struct packed {
        logic load;   // append i_value to the list named by the command
        logic clear;  // merge of two empty lists: drop the overflow flag
        logic step;   // emit one merged value
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;      // both lists hold nothing
        logic out_free;   // output register can take a value this cycle
        logic last_step;  // the value emitted by a step ends the run
    } t_dp_status;

endpackage

// ===== rtl/stwm_ram.sv =====
// ----------------------------------------------------------------------------
// stwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/stwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// stwm_ctrl
// Controller: takes commands while idle and sequences the merge steps.
// ----------------------------------------------------------------------------
module stwm_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [stwm_pkg::COMMAND_W-1:0] i_command,
    input  stwm_pkg::t_dp_status         i_status,
    output stwm_pkg::t_dp_cmd            o_cmd
);
    import stwm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_transfer;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_transfer = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.clear = 1'b0;
        o_cmd.step  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_transfer) begin
                    if (i_command == CMD_LOAD_FIRST || i_command == CMD_LOAD_SECOND) begin
                        o_cmd.load = 1'b1;
                    end else if (i_command == CMD_MERGE) begin
                        if (i_status.empty) begin
                            o_cmd.clear = 1'b1;
                        end else begin
                            n_state = ST_MERGE;
                        end
                    end
                end
            end
            ST_MERGE: begin
                o_cmd.step = i_status.out_free;
                if (i_status.out_free && i_status.last_step) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/stwm_dp.sv =====
// ----------------------------------------------------------------------------
// stwm_dp
// Datapath: list stores, fill counts, read indices, compare and output
// register.
// ----------------------------------------------------------------------------
module stwm_dp #(
    parameter int LIST_DEPTH = stwm_pkg::LIST_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [stwm_pkg::COMMAND_W-1:0] i_command,
    input  logic signed [stwm_pkg::VALUE_W-1:0] i_value,
    input  stwm_pkg::t_dp_cmd              i_cmd,
    output stwm_pkg::t_dp_status           o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [stwm_pkg::VALUE_W-1:0] o_merged_value,
    output logic                           o_last,
    output logic                           o_overflow
);
    import stwm_pkg::*;

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

    logic [CNT_W-1:0]   r_cnt1, r_cnt2;
    logic [CNT_W-1:0]   r_i, r_j, n_i, n_j;
    logic               r_dropped;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last;
    logic               r_out_overflow;

    logic [VALUE_W-1:0] rd1, rd2;
    logic               wr1, wr2;
    logic               full1, full2;
    logic               more1, more2;
    logic               take_first;
    logic [CNT_W-1:0]   step_i, step_j;
    logic               last_step;

    assign full1 = (r_cnt1 == CNT_W'(LIST_DEPTH));
    assign full2 = (r_cnt2 == CNT_W'(LIST_DEPTH));
    assign wr1   = i_cmd.load && (i_command == CMD_LOAD_FIRST) && !full1;
    assign wr2   = i_cmd.load && (i_command == CMD_LOAD_SECOND) && !full2;

    // Read data always shows the entries at r_i and r_j: read one ahead.
    stwm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH), .ADDR_W(ADDR_W)) u_first_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr1),
        .i_wr_addr (r_cnt1[ADDR_W-1:0]),
        .i_wr_data (i_value),
        .i_rd_addr (n_i[ADDR_W-1:0]),
        .o_rd_data (rd1)
    );

    stwm_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH), .ADDR_W(ADDR_W)) u_second_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr2),
        .i_wr_addr (r_cnt2[ADDR_W-1:0]),
        .i_wr_data (i_value),
        .i_rd_addr (n_j[ADDR_W-1:0]),
        .o_rd_data (rd2)
    );

    assign more1      = (r_i < r_cnt1);
    assign more2      = (r_j < r_cnt2);
    // ties go to the first list
    assign take_first = more1 && (!more2 || ($signed(rd1) <= $signed(rd2)));
    assign step_i     = r_i + CNT_W'(take_first);
    assign step_j     = r_j + CNT_W'(!take_first);
    assign last_step  = (step_i == r_cnt1) && (step_j == r_cnt2);

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        if (i_cmd.step) begin
            if (last_step) begin
                n_i = '0;
                n_j = '0;
            end else begin
                n_i = step_i;
                n_j = step_j;
            end
        end
    end

    assign o_status.empty     = (r_cnt1 == '0) && (r_cnt2 == '0);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_status.last_step = last_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt1      <= '0;
            r_cnt2      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_i <= n_i;
            r_j <= n_j;
            if (wr1) begin
                r_cnt1 <= r_cnt1 + CNT_W'(1);
            end
            if (wr2) begin
                r_cnt2 <= r_cnt2 + CNT_W'(1);
            end
            if (i_cmd.load && ((i_command == CMD_LOAD_FIRST && full1) ||
                               (i_command == CMD_LOAD_SECOND && full2))) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_dropped <= 1'b0;
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
                if (last_step) begin
                    r_cnt1    <= '0;
                    r_cnt2    <= '0;
                    r_dropped <= 1'b0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_value    <= take_first ? rd1 : rd2;
            r_out_last     <= last_step;
            r_out_overflow <= r_dropped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_last         = r_out_last;
    assign o_overflow     = r_out_overflow;

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i <= r_cnt1) && (r_j <= r_cnt2))
        else $error("merge index beyond list fill");

    a_step_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (more1 || more2))
        else $error("merge step with both lists exhausted");

    a_lists_emptied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && last_step) |=> (r_cnt1 == '0 && r_cnt2 == '0 && !r_dropped))
        else $error("lists not emptied after final merge step");

    a_no_load_in_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !(wr1 || wr2))
        else $error("list written during a merge");

endmodule

// ===== rtl/sorted_two_way_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_two_way_merge
// Two-list stable merge of signed 64-bit values with overflow flagging.
// ----------------------------------------------------------------------------
// Commands arrive on the input channel. A load (first or second list) gives
// no result; back-to-back loads stream at one per cycle. A merge emits
// first_count + second_count results at one per cycle, set by the single
// read port of each list RAM read one entry ahead, while the output is not
// stalled; the input is stalled for the whole run. A merge of two empty
// lists gives nothing. The last result of a run may still wait in the
// output register while the next load transfers. Loads into a full list
// are dropped and flagged on every result of the next merge. Command 3 is
// ignored.
// ----------------------------------------------------------------------------
module sorted_two_way_merge #(
    parameter int LIST_DEPTH = stwm_pkg::LIST_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [stwm_pkg::COMMAND_W-1:0]      i_command,
    input  logic signed [stwm_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [stwm_pkg::VALUE_W-1:0] o_merged_value,
    output logic                                o_last,
    output logic                                o_overflow
);
    import stwm_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    stwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    stwm_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_merged_value (o_merged_value),
        .o_last         (o_last),
        .o_overflow     (o_overflow)
    );

endmodule

// ===== sim/sorted_two_way_merge_test.sv =====
// ----------------------------------------------------------------------------
// sorted_two_way_merge_test
// Self-checking bench for the stable two-list merge. Loads and merges are
// driven through the input channel with random gaps. A scoreboard mirrors
// both lists and predicts every merged value, the end-of-run mark and the
// overflow flag. Each result transfer is checked against the oldest
// prediction. The receiver stalls in random bursts, including one long
// hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module sorted_two_way_merge_test;
    import stwm_pkg::*;

    localparam int DEPTH        = LIST_DEPTH_DEF;
    localparam int TOTAL_ITEMS  = 110;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;

    // value spreads for list contents
    localparam int SPREAD_FULL   = 0;
    localparam int SPREAD_NARROW = 1;
    localparam int SPREAD_EDGE   = 2;

    typedef logic signed [VALUE_W-1:0] value_t;

    localparam value_t VALUE_MIN = 64'sh8000_0000_0000_0000;
    localparam value_t VALUE_MAX = 64'sh7fff_ffff_ffff_ffff;

    typedef struct packed {
        value_t value;
        logic   last;
        logic   overflow;
    } merge_beat_t;

    class merge_scoreboard;
        value_t      first_list[DEPTH];
        value_t      second_list[DEPTH];
        int          first_count;
        int          second_count;
        bit          dropped;
        merge_beat_t expected_run[$];
        int          errors;
        int          beats_checked;
        int          merges;
        int          flagged_merges;
        int          dropped_loads;

        function new();
            first_count    = 0;
            second_count   = 0;
            dropped        = 0;
            errors         = 0;
            beats_checked  = 0;
            merges         = 0;
            flagged_merges = 0;
            dropped_loads  = 0;
        endfunction

        function void note_input(logic [COMMAND_W-1:0] command, value_t value);
            int          i;
            int          j;
            int          total;
            bit          take_first;
            merge_beat_t beat;
            case (command)
                CMD_LOAD_FIRST: begin
                    if (first_count < DEPTH) begin
                        first_list[first_count] = value;
                        first_count++;
                    end else begin
                        dropped = 1;
                        dropped_loads++;
                    end
                end
                CMD_LOAD_SECOND: begin
                    if (second_count < DEPTH) begin
                        second_list[second_count] = value;
                        second_count++;
                    end else begin
                        dropped = 1;
                        dropped_loads++;
                    end
                end
                CMD_MERGE: begin
                    i     = 0;
                    j     = 0;
                    total = first_count + second_count;
                    while (i < first_count || j < second_count) begin
                        if (i >= first_count)
                            take_first = 0;
                        else if (j >= second_count)
                            take_first = 1;
                        else
                            // ties go to the first list
                            take_first = first_list[i] <= second_list[j];
                        if (take_first) begin
                            beat.value = first_list[i];
                            i++;
                        end else begin
                            beat.value = second_list[j];
                            j++;
                        end
                        beat.last     = (i + j == total);
                        beat.overflow = dropped;
                        expected_run.push_back(beat);
                    end
                    if (total > 0)
                        merges++;
                    if (dropped)
                        flagged_merges++;
                    first_count  = 0;
                    second_count = 0;
                    dropped      = 0;
                end
                default: ;  // unused command: no effect
            endcase
        endfunction

        function void check_result(value_t value, logic last, logic overflow);
            merge_beat_t want;
            if (expected_run.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: value %0d last %b overflow %b",
                         $time, value, last, overflow);
                return;
            end
            want = expected_run.pop_front();
            beats_checked++;
            if (value !== want.value) begin
                errors++;
                $display("%0t: merged_value mismatch: expected %0d, actual %0d",
                         $time, want.value, value);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last mismatch: expected %b, actual %b",
                         $time, want.last, last);
            end
            if (overflow !== want.overflow) begin
                errors++;
                $display("%0t: overflow mismatch: expected %b, actual %b",
                         $time, want.overflow, overflow);
            end
        endfunction

        function int pending();
            return expected_run.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic [COMMAND_W-1:0] i_command   = CMD_LOAD_FIRST;
    value_t               i_value     = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    value_t               o_merged_value;
    logic                 o_last;
    logic                 o_overflow;

    merge_scoreboard sb;
    int              items_sent    = 0;
    int              quiet_from    = 32'h7fff_ffff;
    bit              quiet         = 0;
    bit              long_hold_req = 0;

    sorted_two_way_merge #(
        .LIST_DEPTH(DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_merged_value(o_merged_value),
        .o_last        (o_last),
        .o_overflow    (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_merged_value, o_last, o_overflow);
    end

    // receiver: random stall bursts, calm stretches and one long hold on request
    initial begin
        int burst;
        int calm;
        burst = 0;
        calm  = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 0;
                burst         = LONG_HOLD;
            end
            if (burst > 0) begin
                i_out_stall = 1'b1;
                burst--;
            end else if (quiet || calm > 0) begin
                i_out_stall = 1'b0;
                if (calm > 0)
                    calm--;
            end else if ($urandom_range(0, 19) == 0) begin
                i_out_stall = 1'b0;
                calm        = $urandom_range(20, 60);
            end else if ($urandom_range(0, 6) == 0) begin
                i_out_stall = 1'b1;
                burst       = $urandom_range(1, 15) - 1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic value_t pick_value(int spread);
        value_t v;
        case (spread)
            SPREAD_FULL:   v = {$urandom, $urandom};
            SPREAD_NARROW: v = value_t'(int'($urandom_range(0, 15)) - 8);
            default: begin
                case ($urandom_range(0, 6))
                    0:       v = VALUE_MIN;
                    1:       v = VALUE_MIN + 1;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    5:       v = VALUE_MAX - 1;
                    default: v = VALUE_MAX;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic sender_gap(int cycles);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // offer one item and hold it until the block takes it
    task automatic transfer_item(logic [COMMAND_W-1:0] command, value_t value);
        if (!quiet && $urandom_range(0, 5) == 0)
            sender_gap($urandom_range(1, 15));
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_command  = command;
        i_value    = value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(command, value);
        if (command != CMD_UNUSED)
            items_sent++;
        quiet = items_sent >= quiet_from;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // load both lists interleaved at random, then merge
    task automatic run_list_pair(int n_first, int n_second, bit keep_sorted, int spread);
        longint first_q[$];
        longint second_q[$];
        bit     pick_first;
        repeat (n_first) first_q.push_back(longint'(pick_value(spread)));
        repeat (n_second) second_q.push_back(longint'(pick_value(spread)));
        if (keep_sorted) begin
            first_q.sort();
            second_q.sort();
        end
        while (first_q.size() > 0 || second_q.size() > 0) begin
            if (first_q.size() == 0)
                pick_first = 0;
            else if (second_q.size() == 0)
                pick_first = 1;
            else
                pick_first = $urandom_range(0, 1);
            if ($urandom_range(0, 19) == 0)
                transfer_item(CMD_UNUSED, pick_value(SPREAD_FULL));
            if (pick_first)
                transfer_item(CMD_LOAD_FIRST, value_t'(first_q.pop_front()));
            else
                transfer_item(CMD_LOAD_SECOND, value_t'(second_q.pop_front()));
        end
        transfer_item(CMD_MERGE, pick_value(SPREAD_FULL));
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // merge of two empty lists, then an ignored command
        transfer_item(CMD_MERGE, VALUE_MAX);
        transfer_item(CMD_UNUSED, VALUE_MIN);
        // extremes on both sides with ties
        transfer_item(CMD_LOAD_FIRST, VALUE_MIN);
        transfer_item(CMD_LOAD_SECOND, VALUE_MIN);
        transfer_item(CMD_LOAD_FIRST, -1);
        transfer_item(CMD_LOAD_SECOND, 0);
        transfer_item(CMD_LOAD_FIRST, 0);
        transfer_item(CMD_LOAD_SECOND, 0);
        transfer_item(CMD_LOAD_FIRST, VALUE_MAX);
        transfer_item(CMD_LOAD_SECOND, VALUE_MAX);
        transfer_item(CMD_MERGE, 0);
        // one list only, each side
        transfer_item(CMD_LOAD_FIRST, 5);
        transfer_item(CMD_MERGE, -1);
        transfer_item(CMD_LOAD_SECOND, -7);
        transfer_item(CMD_LOAD_SECOND, 3);
        transfer_item(CMD_MERGE, 0);
        // unsorted lists
        transfer_item(CMD_LOAD_FIRST, 9);
        transfer_item(CMD_LOAD_SECOND, 5);
        transfer_item(CMD_LOAD_FIRST, 1);
        transfer_item(CMD_LOAD_SECOND, -2);
        transfer_item(CMD_MERGE, VALUE_MIN);
        wait_drained();

        quiet_from = TOTAL_ITEMS * 3 / 4;

        // overfill the first list
        run_list_pair(DEPTH + 2, 3, 1, SPREAD_NARROW);
        wait_drained();
        // long receiver hold while the sender keeps offering
        long_hold_req = 1;
        run_list_pair(6, 7, 1, SPREAD_FULL);
        // overfill the second list
        run_list_pair(0, DEPTH + 1, 1, SPREAD_FULL);
        wait_drained();

        while (items_sent < TOTAL_ITEMS) begin
            run_list_pair($urandom_range(0, 6), $urandom_range(0, 6),
                          $urandom_range(0, 9) != 0,
                          $urandom_range(SPREAD_FULL, SPREAD_EDGE));
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d loads and merges; checked %0d results from %0d non-empty merges.",
                 items_sent, sb.beats_checked, sb.merges);
        $display("Full-list drops: %0d loads, flagged on %0d merges.",
                 sb.dropped_loads, sb.flagged_merges);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sorted_two_way_merge.f =====
rtl/stwm_pkg.sv
rtl/stwm_ram.sv
rtl/stwm_ctrl.sv
rtl/stwm_dp.sv
rtl/sorted_two_way_merge.sv
sim/sorted_two_way_merge_test.sv
